// ===== rtl/core/mlft_pkg.sv =====
// Package for the learning bridge MAC table: sizes, command record and
// sequencer states. Shared by every module under rtl/core; no dependencies.
package mlft_pkg;

   // Table and field sizes
   localparam int TABLE_ENTRIES = 64;
   localparam int PORT_COUNT    = 16;
   localparam int MAC_W         = 48;
   localparam int PORT_W        = 4;

   // Search organization: LANES entries compared per cycle, ROWS rows per scan
   localparam int LANES  = (TABLE_ENTRIES >= 8) ? 8 : 2;
   localparam int LANE_W = $clog2(LANES);
   localparam int ROWS   = (TABLE_ENTRIES + LANES - 1) / LANES;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int SLOT_W = $clog2(ROWS * LANES) + 1;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stream payload widths
   localparam int REQ_TDATA_W = 104;
   localparam int RSP_TDATA_W = 8;

   // One classified frame header
   typedef struct packed {
      logic              learn;
      logic [MAC_W-1:0]  src_mac;
      logic [PORT_W-1:0] port;
      logic [MAC_W-1:0]  dst_mac;
   } cmd_type;

   // Back-end sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESOLVE
   } back_state_type;

endpackage

// ===== rtl/core/mlft_front.sv =====
// Front end: takes request transactions, decides whether the source is
// learned, and holds the command until the queue takes it. Uses mlft_pkg.
module mlft_front import mlft_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // src_mac, ingress_port, dest_mac
   input  logic                   req_tuser,  // source_valid
   output cmd_type                q_cmd,
   output logic                   q_push,
   input  logic                   q_ready
);

   logic    hold_valid_ff, hold_valid_in;
   cmd_type cmd_ff, cmd_in;
   logic    accept;

   // Ready when the holding register is empty or drains this cycle
   assign req_tready = !hold_valid_ff || q_ready;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = hold_valid_ff;
   assign q_cmd      = cmd_ff;

   // Classify: learn only a present source on an in-range port
   always_comb begin
      cmd_in.src_mac = req_tdata[MAC_W-1:0];
      cmd_in.port    = req_tdata[MAC_W+PORT_W-1:MAC_W];
      cmd_in.dst_mac = req_tdata[2*MAC_W+PORT_W-1:MAC_W+PORT_W];
      cmd_in.learn   = req_tuser && (32'(cmd_in.port) < PORT_COUNT);
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (q_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ===== rtl/core/mlft_queue.sv =====
// Short command queue decoupling the front end from the table sequencer.
// Uses mlft_pkg for the command record and depth.
module mlft_queue import mlft_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cmd_type in_cmd,
   input  logic    in_valid,
   output logic    in_ready,
   output cmd_type out_cmd,
   output logic    out_valid,
   input  logic    out_pop
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;

   assign in_ready  = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ===== rtl/core/mlft_back.sv =====
// Back end: scans the MAC table a row of lanes per cycle, learns the source,
// resolves the destination and holds the response. Uses mlft_pkg.
module mlft_back import mlft_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                q_cmd,
   input  logic                   q_valid,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // out_port, zero fill
   output logic                   rsp_tuser   // hit
);

   back_state_type      state_ff, state_in;
   cmd_type             cmd_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [ROW_W-1:0]    rd_row_ff;
   logic                rd_valid_ff;
   logic                src_hit_ff;
   logic [IDX_W-1:0]    src_slot_ff;
   logic                dst_hit_ff;
   logic [IDX_W-1:0]    dst_slot_ff;
   logic [PORT_W-1:0]   dst_port_ff;
   logic [SLOT_W-1:0]   fill_ff;
   logic [IDX_W-1:0]    ptr_ff;
   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic [PORT_W-1:0]   rsp_port_ff;

   logic                scan_en, out_free, resolve_go, wr_en;
   logic [LANES-1:0]    src_match, dst_match;
   logic [PORT_W-1:0]   lane_port [LANES];
   logic                row_src_hit, row_dst_hit;
   logic [LANE_W-1:0]   row_src_lane, row_dst_lane;
   logic                full, replaced;
   logic [IDX_W-1:0]    wr_slot;
   logic [LANE_W-1:0]   wr_lane;
   logic [ROW_W-1:0]    wr_row;
   logic                res_hit;
   logic [PORT_W-1:0]   res_port;

   // Sequencer outputs
   always_comb begin
      q_pop      = (state_ff == ST_IDLE) && q_valid;
      scan_en    = (state_ff == ST_SCAN);
      out_free   = !rsp_valid_ff || rsp_tready;
      resolve_go = (state_ff == ST_RESOLVE) && out_free;
      wr_en      = resolve_go && cmd_ff.learn;
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (row_ff == ROW_W'(ROWS - 1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Table lanes: one memory per lane, entry index = row * LANES + lane
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [MAC_W-1:0]  mac_mem  [ROWS];
      logic [PORT_W-1:0] port_mem [ROWS];
      logic [MAC_W-1:0]  rd_mac_ff;
      logic [PORT_W-1:0] rd_port_ff;
      logic [SLOT_W-1:0] lane_idx;
      logic              lane_valid;

      always_ff @(posedge clock) begin
         if (wr_en && (wr_lane == LANE_W'(l))) begin
            mac_mem[wr_row]  <= cmd_ff.src_mac;
            port_mem[wr_row] <= cmd_ff.port;
         end
         if (scan_en) begin
            rd_mac_ff  <= mac_mem[row_ff];
            rd_port_ff <= port_mem[row_ff];
         end
      end

      // Entries below the fill count are valid
      assign lane_idx     = (SLOT_W'(rd_row_ff) << LANE_W) | SLOT_W'(l);
      assign lane_valid   = lane_idx < fill_ff;
      assign src_match[l] = lane_valid && (rd_mac_ff == cmd_ff.src_mac);
      assign dst_match[l] = lane_valid && (rd_mac_ff == cmd_ff.dst_mac);
      assign lane_port[l] = rd_port_ff;
   end

   // Lowest matching lane in the row just read
   always_comb begin
      row_src_hit  = |src_match;
      row_dst_hit  = |dst_match;
      row_src_lane = '0;
      row_dst_lane = '0;
      for (int l = LANES - 1; l >= 0; l--) begin
         if (src_match[l]) row_src_lane = LANE_W'(l);
         if (dst_match[l]) row_dst_lane = LANE_W'(l);
      end
   end

   // Learn slot choice and response
   always_comb begin
      full     = fill_ff == SLOT_W'(TABLE_ENTRIES);
      replaced = 1'b0;
      if (src_hit_ff) begin
         wr_slot = src_slot_ff;
      end else if (!full) begin
         wr_slot = IDX_W'(fill_ff);
      end else begin
         wr_slot  = ptr_ff;
         replaced = 1'b1;
      end
      wr_lane = wr_slot[LANE_W-1:0];
      wr_row  = ROW_W'(SLOT_W'(wr_slot) >> LANE_W);

      res_hit  = 1'b0;
      res_port = '0;
      if (cmd_ff.learn && (cmd_ff.src_mac == cmd_ff.dst_mac)) begin
         res_hit  = 1'b1;
         res_port = cmd_ff.port;
      end else if (dst_hit_ff &&
                   !(cmd_ff.learn && replaced && (dst_slot_ff == ptr_ff))) begin
         res_hit  = 1'b1;
         res_port = dst_port_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= scan_en;
         if (wr_en && !src_hit_ff) begin
            if (!full) begin
               fill_ff <= fill_ff + SLOT_W'(1);
            end else begin
               ptr_ff <= (ptr_ff == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : ptr_ff + IDX_W'(1);
            end
         end
         if (resolve_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Scan and match registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff     <= q_cmd;
         row_ff     <= '0;
         src_hit_ff <= 1'b0;
         dst_hit_ff <= 1'b0;
      end else begin
         if (scan_en) begin
            row_ff    <= row_ff + ROW_W'(1);
            rd_row_ff <= row_ff;
         end
         if (rd_valid_ff && !src_hit_ff && row_src_hit) begin
            src_hit_ff  <= 1'b1;
            src_slot_ff <= IDX_W'((SLOT_W'(rd_row_ff) << LANE_W) | SLOT_W'(row_src_lane));
         end
         if (rd_valid_ff && !dst_hit_ff && row_dst_hit) begin
            dst_hit_ff  <= 1'b1;
            dst_slot_ff <= IDX_W'((SLOT_W'(rd_row_ff) << LANE_W) | SLOT_W'(row_dst_lane));
            dst_port_ff <= lane_port[row_dst_lane];
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (resolve_go) begin
         rsp_hit_ff  <= res_hit;
         rsp_port_ff <= res_port;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - PORT_W){1'b0}}, rsp_port_ff};

endmodule

// ===== rtl/core/mac_learning_forward_table_unit.sv =====
// Channel   Direction  tdata (low bit up)                           tuser
// req_      in         src_mac[47:0] ingress_port[51:48]            source_valid
//                      dest_mac[99:52], zero fill to 104
// rsp_      out        out_port[3:0], zero fill to 8                hit
//
// Each header runs through the sequencer states in order: ST_IDLE issues it,
// ST_SCAN reads the lane memories a row per cycle, ST_DRAIN compares the last
// row, ST_RESOLVE writes the learned entry and loads the response. Reset is
// synchronous and clears the fill count, replacement pointer, queue and
// handshakes; table contents need no clearing. The front end and queue take
// headers while the sequencer works or a response waits, until they fill.
// Top level of the learning bridge MAC table; uses mlft_pkg, mlft_front,
// mlft_queue and mlft_back.
module mac_learning_forward_table_unit import mlft_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // src_mac, ingress_port, dest_mac
   input  logic                   req_tuser,  // source_valid
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // out_port
   output logic                   rsp_tuser   // hit
);

   cmd_type front_cmd, back_cmd;
   logic    front_push, queue_ready, queue_valid, back_pop;

   mlft_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_cmd      (front_cmd),
      .q_push     (front_push),
      .q_ready    (queue_ready)
   );

   mlft_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_cmd    (front_cmd),
      .in_valid  (front_push),
      .in_ready  (queue_ready),
      .out_cmd   (back_cmd),
      .out_valid (queue_valid),
      .out_pop   (back_pop)
   );

   mlft_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_cmd      (back_cmd),
      .q_valid    (queue_valid),
      .q_pop      (back_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
